/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared property forms for the checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

/* rtl/core/imu_ocl_pkg.sv */
// ----------------------------------------------------------------------------
// imu_ocl_pkg
// shared types and constants of the imu offset calibration and low-pass block
// ----------------------------------------------------------------------------
package imu_ocl_pkg;

    localparam int AXES          = 6;
    localparam int AXIS_W        = 3;
    localparam int DATA_W        = 16;
    localparam int SUM_W         = 30;
    localparam int CNT_W         = 13;
    localparam int CAL_COUNT_DEF = 512;
    localparam int W_W           = 16;
    localparam int G_W           = 15;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int SUM_MAG_W     = SUM_W - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = CFG_IDX_W'(1);

    localparam logic [W_W-1:0] W_RESET = W_W'(52429);
    localparam logic [G_W-1:0] G_RESET = G_W'(16384);

    localparam logic [AXIS_W-1:0] AXIS_ACCEL_Z = AXIS_W'(2);
    localparam logic [AXIS_W-1:0] AXIS_GYRO_0  = AXIS_W'(3);
    localparam logic [AXIS_W-1:0] AXIS_LAST    = AXIS_W'(AXES - 1);

    // gyro scaling: x * 128 / 131 rounded, done as a reciprocal multiply
    localparam int GYRO_DIV    = 131;
    localparam int GYRO_SH     = 7;
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 23;
    localparam int N_W         = 24;
    localparam int PROD_W      = N_W + RECIP_W;
    localparam logic [RECIP_W-1:0] GYRO_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + GYRO_DIV - 1) / GYRO_DIV);
    localparam logic [N_W-1:0] GYRO_ROUND = N_W'((GYRO_DIV - 1) / 2);

    localparam logic signed [SUM_W-1:0] SAT_HI = 32767;
    localparam logic signed [SUM_W-1:0] SAT_LO = -32768;

    typedef struct packed {
        logic              cap;
        logic              acc;
        logic              div_load;
        logic              div_step;
        logic              div_store;
        logic              sub;
        logic              mul;
        logic              sat;
        logic              fmul;
        logic              fadd;
        logic              prime;
        logic              out_load;
        logic [AXIS_W-1:0] axis;
    } dp_cmd_t;

    function automatic logic [DATA_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[DATA_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[DATA_W-1:0];
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/core/imu_ocl_datapath.sv */
// ----------------------------------------------------------------------------
// imu_ocl_datapath
// sample store, offset sums, offset divider, axis conversion and filter unit
// ----------------------------------------------------------------------------
module imu_ocl_datapath #(
    parameter int CAL_COUNT = imu_ocl_pkg::CAL_COUNT_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  logic [imu_ocl_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [imu_ocl_pkg::CFG_DATA_W-1:0]            cfg_data,
    input  logic [imu_ocl_pkg::AXES*imu_ocl_pkg::DATA_W-1:0] in_data,
    input  imu_ocl_pkg::dp_cmd_t                          cmd,
    output logic [imu_ocl_pkg::AXES*imu_ocl_pkg::DATA_W-1:0] out_data
);

    localparam int DW       = imu_ocl_pkg::DATA_W;
    localparam int SW       = imu_ocl_pkg::SUM_W;
    localparam int QW       = imu_ocl_pkg::SUM_MAG_W;
    localparam int PW       = imu_ocl_pkg::PROD_W;
    localparam int MW       = 2 * (DW + 1);
    // offset average as a reciprocal multiply, exact for every sum magnitude
    localparam int DIV_SH   = QW + $clog2(CAL_COUNT);
    localparam int DRECIP_W = QW + 1;
    localparam int DPROD_W  = QW + DRECIP_W;
    localparam logic [DRECIP_W-1:0] DIV_RECIP =
        DRECIP_W'(((64'd1 << DIV_SH) + 64'(CAL_COUNT) - 64'd1) / 64'(CAL_COUNT));

    logic [imu_ocl_pkg::W_W-1:0] w_reg;
    logic [imu_ocl_pkg::G_W-1:0] g_reg;
    logic [DW-1:0]               raw_reg  [imu_ocl_pkg::AXES];
    logic [SW-1:0]               sum_reg  [imu_ocl_pkg::AXES];
    logic [DW-1:0]               off_reg  [imu_ocl_pkg::AXES];
    logic [DW-1:0]               filt_reg [imu_ocl_pkg::AXES];
    logic [DW-1:0]               out_reg  [imu_ocl_pkg::AXES];
    logic [DW:0]                 d_reg;
    logic                        neg_reg;
    logic [PW-1:0]               prod_reg;
    logic [DW-1:0]               x_reg;
    logic signed [MW-1:0]        p_reg;
    logic [QW-1:0]               mag_reg;
    logic [DPROD_W-1:0]          dprod_reg;
    logic                        qneg_reg;

    logic [DW-1:0]               raw_sel;
    logic [SW-1:0]               sum_sel;
    logic [SW-1:0]               acc_val;
    logic [SW-1:0]               sum_mag;
    logic [QW-1:0]               quo_val;
    logic [SW-1:0]               quo_ext;
    logic [SW-1:0]               quo_signed;
    logic [DW:0]                 d_mag;
    logic [imu_ocl_pkg::N_W-1:0] n_val;
    logic [DW:0]                 q_val;
    logic [SW-1:0]               q_ext;
    logic [SW-1:0]               conv_val;
    logic signed [DW:0]          w_s;
    logic signed [DW:0]          diff_s;
    logic [MW-1:0]               p_round;

    always_comb
    begin
        raw_sel = raw_reg[cmd.axis];
        sum_sel = sum_reg[cmd.axis];
        acc_val = {{(SW-DW){raw_sel[DW-1]}}, raw_sel};
        if (cmd.axis == imu_ocl_pkg::AXIS_ACCEL_Z)
        begin
            acc_val = acc_val - {{(SW-imu_ocl_pkg::G_W){1'b0}}, g_reg};
        end
        sum_mag    = sum_sel[SW-1] ? (~sum_sel + 1'b1) : sum_sel;
        quo_val    = QW'(dprod_reg >> DIV_SH);
        quo_ext    = {1'b0, quo_val};
        quo_signed = qneg_reg ? (~quo_ext + 1'b1) : quo_ext;

        d_mag = d_reg[DW] ? (~d_reg + 1'b1) : d_reg;
        n_val = {d_mag, {imu_ocl_pkg::GYRO_SH{1'b0}}} + imu_ocl_pkg::GYRO_ROUND;
        q_val = prod_reg[PW-1:imu_ocl_pkg::RECIP_SHIFT];
        q_ext = {{(SW-DW-1){1'b0}}, q_val};
        if (cmd.axis < imu_ocl_pkg::AXIS_GYRO_0)
        begin
            conv_val = {{(SW-DW-1){d_reg[DW]}}, d_reg};
        end
        else
        begin
            conv_val = neg_reg ? (~q_ext + 1'b1) : q_ext;
        end

        w_s     = {1'b0, w_reg};
        diff_s  = {filt_reg[cmd.axis][DW-1], filt_reg[cmd.axis]} - {x_reg[DW-1], x_reg};
        p_round = p_reg + MW'(32768);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= imu_ocl_pkg::W_RESET;
            g_reg <= imu_ocl_pkg::G_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                imu_ocl_pkg::CFG_SMOOTH:  w_reg <= cfg_data[imu_ocl_pkg::W_W-1:0];
                imu_ocl_pkg::CFG_GRAVITY: g_reg <= cfg_data[imu_ocl_pkg::G_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < imu_ocl_pkg::AXES; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (cmd.acc)
        begin
            sum_reg[cmd.axis] <= sum_sel + acc_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            for (int i = 0; i < imu_ocl_pkg::AXES; i++)
            begin
                raw_reg[i] <= in_data[i*DW +: DW];
            end
        end
        if (cmd.div_load)
        begin
            mag_reg  <= sum_mag[QW-1:0];
            qneg_reg <= sum_sel[SW-1];
        end
        if (cmd.div_step)
        begin
            dprod_reg <= mag_reg * DIV_RECIP;
        end
        if (cmd.div_store)
        begin
            off_reg[cmd.axis] <= imu_ocl_pkg::sat16(quo_signed);
        end
        if (cmd.sub)
        begin
            d_reg <= {raw_sel[DW-1], raw_sel} - {off_reg[cmd.axis][DW-1], off_reg[cmd.axis]};
        end
        if (cmd.mul)
        begin
            neg_reg  <= d_reg[DW];
            prod_reg <= n_val * imu_ocl_pkg::GYRO_RECIP;
        end
        if (cmd.sat)
        begin
            x_reg <= imu_ocl_pkg::sat16(conv_val);
        end
        if (cmd.fmul)
        begin
            p_reg <= w_s * diff_s;
        end
        if (cmd.fadd)
        begin
            filt_reg[cmd.axis] <= cmd.prime ? x_reg : x_reg + p_round[DW+DW-1:DW];
        end
        if (cmd.out_load)
        begin
            for (int i = 0; i < imu_ocl_pkg::AXES; i++)
            begin
                out_reg[i] <= filt_reg[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < imu_ocl_pkg::AXES; i++)
        begin
            out_data[i*DW +: DW] = out_reg[i];
        end
    end

endmodule

/* rtl/core/imu_ocl_ctrl.sv */
// ----------------------------------------------------------------------------
// imu_ocl_ctrl
// sequencer for calibration, offset division, per-axis filtering and output
// ----------------------------------------------------------------------------
module imu_ocl_ctrl #(
    parameter int CAL_COUNT = imu_ocl_pkg::CAL_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output imu_ocl_pkg::dp_cmd_t cmd
);

    localparam int CW     = imu_ocl_pkg::CNT_W;
    localparam int AW     = imu_ocl_pkg::AXIS_W;
    localparam logic [CW-1:0]     CAL_LIMIT = CW'(CAL_COUNT);

    localparam logic [1:0] PH_CAL   = 2'd0;
    localparam logic [1:0] PH_PRIME = 2'd1;
    localparam logic [1:0] PH_RUN   = 2'd2;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ACC    = 4'd1;
    localparam logic [3:0] S_DLOAD  = 4'd2;
    localparam logic [3:0] S_DSTEP  = 4'd3;
    localparam logic [3:0] S_DSTORE = 4'd4;
    localparam logic [3:0] S_SUB    = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_SAT    = 4'd7;
    localparam logic [3:0] S_FMUL   = 4'd8;
    localparam logic [3:0] S_FADD   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     axis_reg, axis_next;
    logic              out_valid_reg, out_valid_next;
    logic [CW-1:0]     cnt_inc;
    logic              last_axis;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg;
        cnt_inc        = cnt_reg + 1'b1;
        last_axis      = (axis_reg == imu_ocl_pkg::AXIS_LAST);
        cmd            = '0;
        cmd.axis       = axis_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap    = 1'b1;
                    axis_next  = '0;
                    state_next = (phase_reg == PH_CAL) ? S_ACC : S_SUB;
                end
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (last_axis)
                begin
                    cnt_next   = cnt_inc;
                    axis_next  = '0;
                    state_next = (cnt_inc >= CAL_LIMIT) ? S_DLOAD : S_IDLE;
                end
                else
                begin
                    axis_next = axis_reg + 1'b1;
                end
            end
            S_DLOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.div_step = 1'b1;
                state_next   = S_DSTORE;
            end
            S_DSTORE:
            begin
                cmd.div_store = 1'b1;
                if (last_axis)
                begin
                    axis_next  = '0;
                    phase_next = PH_PRIME;
                    state_next = S_IDLE;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_DLOAD;
                end
            end
            S_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SAT;
            end
            S_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                cmd.fmul   = 1'b1;
                state_next = S_FADD;
            end
            S_FADD:
            begin
                cmd.fadd  = 1'b1;
                cmd.prime = (phase_reg == PH_PRIME);
                if (!last_axis)
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_SUB;
                end
                else
                begin
                    axis_next = '0;
                    if (phase_reg == PH_PRIME)
                    begin
                        phase_next = PH_RUN;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_CAL;
            cnt_reg       <= '0;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/imu_offset_calibrate_lowpass_top.sv */
// ----------------------------------------------------------------------------
// imu_offset_calibrate_lowpass_top
// six-axis imu bias calibration followed by an exponential low-pass filter
// ----------------------------------------------------------------------------
// s_axis takes one raw sample per item: accel x/y/z then rate x/y/z, 16 bits
// each. the first CAL_COUNT items build per-axis offsets and give no result,
// the next item primes the filter, and every later item gives one m_axis item
// of six filtered values (accel in q2.14 g, rate in q9.7 deg/s).
// cfg writes set smoothing_weight (index 0) and gravity_counts (index 1) and
// are always taken; write them only while the block is idle.
// a calibration item is accepted and then added to the sums axis by axis; the
// last one then runs the offset division (6 axes in turn, each: magnitude,
// reciprocal multiply, store). priming runs the filter steps with no output
// load. a filtered item takes 5 steps per axis through the shared subtract,
// scale, saturate and filter multiplier path, then the output load.
// the result sits in an output register, so the next item is accepted while
// m_axis is stalled; only the output load of that next item waits for it.
// reset clears the sums and counters, sets the config registers to their reset
// values and restarts calibration; no clearing pass is needed.
// ----------------------------------------------------------------------------
module imu_offset_calibrate_lowpass_top #(
    parameter int CAL_COUNT = imu_ocl_pkg::CAL_COUNT_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
    input  logic [imu_ocl_pkg::AXES*imu_ocl_pkg::DATA_W-1:0] s_axis_tdata,
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // smooth_accel_x, _y, _z, smooth_rate_x, _y, _z
    output logic [imu_ocl_pkg::AXES*imu_ocl_pkg::DATA_W-1:0] m_axis_tdata,
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic [imu_ocl_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [imu_ocl_pkg::CFG_DATA_W-1:0]           cfg_data
);

    imu_ocl_pkg::dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    imu_ocl_ctrl #(
        .CAL_COUNT (CAL_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    imu_ocl_datapath #(
        .CAL_COUNT (CAL_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .out_data  (m_axis_tdata)
    );

endmodule

/* rtl/core/imu_ocl_checker.sv */
// ----------------------------------------------------------------------------
// imu_ocl_checker
// port-level checks of the imu calibration and filter block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imu_ocl_checker (
    input logic                                         clk,
    input logic                                         rst_n,
    input logic                                         s_axis_tvalid,
    input logic                                         s_axis_tready,
    input logic [imu_ocl_pkg::AXES*imu_ocl_pkg::DATA_W-1:0] s_axis_tdata,
    input logic                                         m_axis_tvalid,
    input logic                                         m_axis_tready,
    input logic [imu_ocl_pkg::AXES*imu_ocl_pkg::DATA_W-1:0] m_axis_tdata,
    input logic                                         cfg_valid,
    input logic                                         cfg_ready,
    input logic [imu_ocl_pkg::CFG_IDX_W-1:0]            cfg_index,
    input logic [imu_ocl_pkg::CFG_DATA_W-1:0]           cfg_data
);

    // stalled result holds
    `ASSERT_CLK(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    `ASSERT_CLK(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    // an item keeps the block busy after it is accepted
    `ASSERT_CLK(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    // a result never follows its input in the next cycle
    `ASSERT_NEVER(a_no_instant_result, clk, rst_n, $rose(m_axis_tvalid) && $past(s_axis_tvalid && s_axis_tready))

endmodule

bind imu_offset_calibrate_lowpass_top imu_ocl_checker u_checker (.*);

/* tb/tb_imu_offset_calibrate_lowpass_top.sv */
// ----------------------------------------------------------------------------
// tb_imu_offset_calibrate_lowpass_top
// self-checking bench for the imu offset calibration and low-pass block
// ----------------------------------------------------------------------------
// a scoreboard class predicts every filtered item from the accepted samples and
// the register writes, and compares each m_axis item field by field. the
// calibration phase feeds field extremes, then samples near the rails so that
// the offsets land at the extremes and the z offset saturates. gravity_counts
// changes between calibration chunks. the filter runs the reset, zero, full,
// half, random and lsb weights; stream sides idle at random except in one phase.
// ----------------------------------------------------------------------------
module tb_imu_offset_calibrate_lowpass_top;

    import imu_ocl_pkg::*;

    localparam int CAL_ITEMS     = CAL_COUNT_DEF;
    localparam int SETTLE_CYCLES = 300;
    localparam int STALL_LIMIT   = 5000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

    typedef logic [AXES-1:0][DATA_W-1:0] axes_t;
    typedef enum logic [1:0] {CALIBRATING, PRIMING, RUNNING} cal_phase_e;

    class imu_filter_scoreboard;
        int         cal_items;
        int         cal_taken;
        int         mismatches;
        cal_phase_e cal_phase;
        longint     weight;
        longint     gravity;
        longint     offset_sum[AXES];
        longint     axis_offset[AXES];
        longint     smoothed[AXES];
        axes_t      expected_smooth[$];
        string      out_names[AXES] = '{"smooth_accel_x", "smooth_accel_y",
                                        "smooth_accel_z", "smooth_rate_x",
                                        "smooth_rate_y", "smooth_rate_z"};

        function new(int n);
            cal_items  = n;
            cal_taken  = 0;
            mismatches = 0;
            cal_phase  = CALIBRATING;
            weight     = W_RESET;
            gravity    = G_RESET;
            for (int i = 0; i < AXES; i++)
            begin
                offset_sum[i]  = 0;
                axis_offset[i] = 0;
                smoothed[i]    = 0;
            end
        endfunction

        function longint clamp16(longint v);
            if (v > 32767)
            begin
                return 32767;
            end
            if (v < -32768)
            begin
                return -32768;
            end
            return v;
        endfunction

        // offset removal, then q2.14 for accel or 128/131 scaling for rate
        function longint to_fixed(int axis, longint raw);
            longint d;
            longint mag;
            longint q;
            d = raw - axis_offset[axis];
            if (axis < AXIS_GYRO_0)
            begin
                return clamp16(d);
            end
            mag = (d < 0) ? -d : d;
            q = ((mag << GYRO_SH) + (GYRO_DIV - 1) / 2) / GYRO_DIV;
            return clamp16((d < 0) ? -q : q);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_SMOOTH)
            begin
                weight = data;
            end
            else if (idx == CFG_GRAVITY)
            begin
                gravity = data[G_W-1:0];
            end
        endfunction

        function void note_sample(axes_t s);
            longint raw;
            longint x;
            longint acc;
            axes_t  out;
            case (cal_phase)
                CALIBRATING:
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        raw = longint'($signed(s[i]));
                        if (i == AXIS_ACCEL_Z)
                        begin
                            raw -= gravity;
                        end
                        offset_sum[i] += raw;
                    end
                    cal_taken++;
                    if (cal_taken >= cal_items)
                    begin
                        for (int i = 0; i < AXES; i++)
                        begin
                            axis_offset[i] = clamp16(offset_sum[i] / cal_items);
                        end
                        cal_phase = PRIMING;
                    end
                end
                PRIMING:
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        smoothed[i] = to_fixed(i, longint'($signed(s[i])));
                    end
                    cal_phase = RUNNING;
                end
                default:
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        x = to_fixed(i, longint'($signed(s[i])));
                        acc = weight * smoothed[i] + ((longint'(1) << W_W) - weight) * x
                            + (longint'(1) << (W_W - 1));
                        smoothed[i] = acc >>> W_W;
                        out[i] = DATA_W'(smoothed[i]);
                    end
                    expected_smooth.push_back(out);
                end
            endcase
        endfunction

        function void check_result(axes_t got);
            axes_t want;
            if (expected_smooth.size() == 0)
            begin
                $error("filtered item with none expected: %h", got);
                mismatches++;
                return;
            end
            want = expected_smooth.pop_front();
            for (int i = 0; i < AXES; i++)
            begin
                if (got[i] !== want[i])
                begin
                    $error("%s: expected %0d, got %0d", out_names[i],
                           $signed(want[i]), $signed(got[i]));
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_smooth.size();
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    axes_t                 s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    axes_t                 m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    int src_idle_pct = 13;
    int snk_idle_pct = 13;
    int stall_cycles = 0;

    imu_filter_scoreboard sb = new(CAL_ITEMS);

    imu_offset_calibrate_lowpass_top #(
        .CAL_COUNT(CAL_ITEMS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic axes_t fill(logic [DATA_W-1:0] v);
        axes_t s;
        for (int i = 0; i < AXES; i++)
        begin
            s[i] = v;
        end
        return s;
    endfunction

    function automatic axes_t alternating(logic [DATA_W-1:0] even, logic [DATA_W-1:0] odd);
        axes_t s;
        for (int i = 0; i < AXES; i++)
        begin
            s[i] = (i % 2 == 0) ? even : odd;
        end
        return s;
    endfunction

    function automatic axes_t random_sample();
        axes_t s;
        for (int i = 0; i < AXES; i++)
        begin
            case ($urandom_range(15))
                0:       s[i] = 16'h8000;
                1:       s[i] = 16'h7fff;
                2:       s[i] = 16'h0000;
                3:       s[i] = 16'hffff;
                default: s[i] = DATA_W'($urandom);
            endcase
        end
        return s;
    endfunction

    // samples held near the rails so the offsets come out at the extremes
    function automatic axes_t rail_sample();
        axes_t s;
        s[0] = DATA_W'(32767 - $urandom_range(255));
        s[1] = DATA_W'(-32768 + $urandom_range(255));
        s[2] = DATA_W'(-32768 + $urandom_range(127));
        s[3] = DATA_W'(30000 + $urandom_range(511) - 256);
        s[4] = DATA_W'(-12000 + $urandom_range(511) - 256);
        s[5] = DATA_W'($urandom_range(1023) - 512);
        return s;
    endfunction

    task automatic send_sample(input axes_t v);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.note_sample(v);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_sample(random_sample());
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_imu_offset_calibrate_lowpass_top: FAIL");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // calibration at the reset gravity, field extremes first
        send_sample(fill(16'h8000));
        send_sample(fill(16'h7fff));
        send_sample(fill(16'h0000));
        send_sample(fill(16'hffff));
        send_sample(alternating(16'h5555, 16'haaaa));
        send_sample(alternating(16'haaaa, 16'h5555));
        go_idle();
        write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom));
        write_reg(CFG_GRAVITY, '0);
        repeat (40) send_sample(rail_sample());
        go_idle();
        write_reg(CFG_GRAVITY, CFG_DATA_W'(32767));
        repeat (400) send_sample(rail_sample());
        go_idle();
        write_reg(CFG_GRAVITY, CFG_DATA_W'($urandom_range(32767)));
        repeat (CAL_ITEMS - 446) send_sample(rail_sample());
        go_idle();

        // priming item, then extremes at the reset weight
        send_sample(random_sample());
        send_sample(fill(16'h8000));
        send_sample(fill(16'h7fff));
        send_sample(fill(16'h0000));
        send_sample(fill(16'hffff));
        send_sample(alternating(16'h5555, 16'haaaa));
        send_sample(alternating(16'h8000, 16'h7fff));
        send_random(200);

        go_idle();
        write_reg(CFG_SMOOTH, '0);
        send_random(150);

        go_idle();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_reg(CFG_SMOOTH, 16'hffff);
        send_random(150);

        go_idle();
        src_idle_pct = 13;
        snk_idle_pct = 13;
        write_reg(CFG_SMOOTH, 16'h8000);
        send_random(150);

        go_idle();
        write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom));
        write_reg(CFG_SMOOTH, CFG_DATA_W'($urandom));
        send_random(200);

        go_idle();
        write_reg(CFG_SMOOTH, CFG_DATA_W'(1));
        write_reg(CFG_GRAVITY, CFG_DATA_W'($urandom_range(32767)));
        send_random(180);

        go_idle();
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("tb_imu_offset_calibrate_lowpass_top: PASS");
        end
        else
        begin
            $display("tb_imu_offset_calibrate_lowpass_top: FAIL");
        end
        $finish;
    end

endmodule
